// ===== design/ffta_pkg.sv =====
// ----------------------------------------------------------------------------
// ffta_pkg
// Shared widths, codes and register map of the first-fit tagged allocator.
// ----------------------------------------------------------------------------
package ffta_pkg;

    localparam int CMD_W    = 1;
    localparam int SIZE_W   = 11;
    localparam int OWNER_W  = 10;
    localparam int START_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int UNITS_W  = 11;

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [UNITS_W-1:0] UNITS_RESET = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_UNITS_IN_USE = 1'b0,
        REG_NONE         = 1'b1
    } reg_idx_t;

endpackage

// ===== design/ffta_if.sv =====
// ----------------------------------------------------------------------------
// ffta_if
// Command and response channels of the allocator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffta_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ffta_pkg::CMD_W-1:0]   command;
    logic [ffta_pkg::SIZE_W-1:0]  alloc_size;
    logic [ffta_pkg::OWNER_W-1:0] owner_id;

    modport source (output valid, output command, output alloc_size, output owner_id,
                    input ready);
    modport sink   (input valid, input command, input alloc_size, input owner_id,
                    output ready);
endinterface

interface ffta_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [ffta_pkg::START_W-1:0] start_unit;
    logic [ffta_pkg::COUNT_W-1:0] freed_count;

    modport source (output valid, output found, output start_unit, output freed_count,
                    input ready);
    modport sink   (input valid, input found, input start_unit, input freed_count,
                    output ready);
endinterface

// ===== design/ffta_apb.sv =====
// ----------------------------------------------------------------------------
// ffta_apb
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module ffta_apb (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffta_pkg::APB_AW-1:0]   paddr,
    input  logic [ffta_pkg::APB_DW-1:0]   pwdata,
    output logic [ffta_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [ffta_pkg::UNITS_W-1:0]  units_in_use
);
    import ffta_pkg::*;

    logic [UNITS_W-1:0] units_reg;
    reg_idx_t           reg_idx;
    logic               wr_en;

    assign reg_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && (reg_idx == REG_UNITS_IN_USE);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_reg <= UNITS_RESET;
        end
        else if (wr_en)
        begin
            units_reg <= pwdata[UNITS_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_UNITS_IN_USE: prdata = APB_DW'(units_reg);
            default:          prdata = '0;
        endcase
    end

    assign units_in_use = units_reg;

endmodule

// ===== design/ffta_store.sv =====
// ----------------------------------------------------------------------------
// ffta_store
// Owner tag memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffta_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ffta_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffta_ctrl
// Scan sequencer: clears the store, runs first-fit search, fill and free
// sweeps one unit per cycle with a shared compare and count unit.
// ----------------------------------------------------------------------------
module ffta_ctrl #(
    parameter int MEM_UNITS  = 1024,
    parameter int OWNER_BITS = 10,
    parameter int AW         = 10,
    parameter int CW         = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ffta_cmd_if.sink                      cmd,
    ffta_rsp_if.source                    rsp,
    input  logic [ffta_pkg::UNITS_W-1:0]  units_in_use,
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output logic [OWNER_BITS-1:0]         mem_wdata,
    output logic [AW-1:0]                 mem_raddr,
    input  logic [OWNER_BITS-1:0]         mem_rdata
);
    import ffta_pkg::*;

    localparam int NW = (CW > UNITS_W) ? CW : UNITS_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [OWNER_BITS-1:0] owner_reg, owner_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               pv_reg, pv_next;
    logic [AW-1:0]      pidx_reg, pidx_next;
    logic [CW-1:0]      run_reg, run_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               found_reg, found_next;
    logic [AW-1:0]      start_reg, start_next;
    logic [AW-1:0]      end_reg, end_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [START_W-1:0] out_start_reg, out_start_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;

    logic [NW-1:0]         n_wide;
    logic [OWNER_BITS-1:0] owner_in;
    logic                  issue;
    logic                  hit;

    assign n_wide   = (NW'(units_in_use) > NW'(MEM_UNITS)) ? NW'(MEM_UNITS)
                                                           : NW'(units_in_use);
    assign owner_in = OWNER_BITS'(cmd.owner_id);
    assign issue    = (idx_reg < n_reg);
    assign hit      = pv_reg && (cmd_reg == CMD_ALLOC) && (mem_rdata == '0)
                      && ((NW'(run_reg) + NW'(1)) == NW'(size_reg));

    assign cmd.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.start_unit  = out_start_reg;
    assign rsp.freed_count = out_count_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        owner_next     = owner_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        run_next       = run_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_found_next = out_found_reg;
        out_start_next = out_start_reg;
        out_count_next = out_count_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[AW-1:0];
        mem_wdata      = '0;
        mem_raddr      = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(MEM_UNITS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next   = cmd_t'(cmd.command);
                    size_next  = cmd.alloc_size;
                    owner_next = owner_in;
                    n_next     = CW'(n_wide);
                    idx_next   = '0;
                    pv_next    = 1'b0;
                    run_next   = '0;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    start_next = '0;
                    state_next = ST_DONE;
                    if (cmd_t'(cmd.command) == CMD_FREE)
                    begin
                        if (owner_in != '0 && n_wide != '0)
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else if (cmd.alloc_size != '0 && owner_in != '0
                             && NW'(cmd.alloc_size) <= n_wide)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (pv_reg)
                begin
                    if (cmd_reg == CMD_FREE)
                    begin
                        if (mem_rdata == owner_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pidx_reg;
                            cnt_next  = cnt_reg + CW'(1);
                        end
                    end
                    else if (mem_rdata != '0)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next = run_reg + CW'(1);
                    end
                end
                if (hit)
                begin
                    found_next = 1'b1;
                    start_next = AW'(NW'(pidx_reg) + NW'(1) - NW'(size_reg));
                    end_next   = pidx_reg;
                    idx_next   = CW'(AW'(NW'(pidx_reg) + NW'(1) - NW'(size_reg)));
                    pv_next    = 1'b0;
                    state_next = ST_FILL;
                end
                else if (issue)
                begin
                    idx_next  = idx_reg + CW'(1);
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[AW-1:0];
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = owner_reg;
                idx_next  = idx_reg + CW'(1);
                if (idx_reg[AW-1:0] == end_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_start_next = START_W'(start_reg);
                    out_count_next = COUNT_W'(cnt_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cmd_reg       <= CMD_ALLOC;
            size_reg      <= '0;
            owner_reg     <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            pv_reg        <= 1'b0;
            pidx_reg      <= '0;
            run_reg       <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            start_reg     <= '0;
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_start_reg <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            size_reg      <= size_next;
            owner_reg     <= owner_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            pv_reg        <= pv_next;
            pidx_reg      <= pidx_next;
            run_reg       <= run_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
            out_found_reg <= out_found_next;
            out_start_reg <= out_start_next;
            out_count_reg <= out_count_next;
        end
    end

endmodule

// ===== design/first_fit_tagged_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_tagged_allocator_core
// First-fit allocator over a tagged unit store with owner-wide free.
//
//   channel   dir   handshake        word
//   cmd       in    valid/ready      command, alloc_size, owner_id
//   rsp       out   valid/ready      found, start_unit, freed_count
//   apb       in    psel/penable     units_in_use at byte address 0
//
// one unit per cycle through the single store read port and compare unit
// allocate: a scan over the n active units, then a fill of each unit of the run, then the rsp load
// free: one sweep over the n active units, n being the active unit count, then the rsp load
// after reset a clearing pass over all MEM_UNITS units holds cmd ready low
// rsp is registered; a waiting word stalls only the end of the next command
// ----------------------------------------------------------------------------
module first_fit_tagged_allocator_core #(
    parameter int MEM_UNITS  = 1024,
    parameter int OWNER_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    ffta_cmd_if.sink                    cmd,
    ffta_rsp_if.source                  rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffta_pkg::APB_AW-1:0] paddr,
    input  logic [ffta_pkg::APB_DW-1:0] pwdata,
    output logic [ffta_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import ffta_pkg::*;

    localparam int AW = (MEM_UNITS > 1) ? $clog2(MEM_UNITS) : 1;
    localparam int CW = $clog2(MEM_UNITS + 1);

    logic [UNITS_W-1:0]    units_in_use;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [OWNER_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [OWNER_BITS-1:0] mem_rdata;

    ffta_apb u_apb (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .units_in_use (units_in_use)
    );

    ffta_store #(
        .DEPTH (MEM_UNITS),
        .AW    (AW),
        .DW    (OWNER_BITS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ffta_ctrl #(
        .MEM_UNITS  (MEM_UNITS),
        .OWNER_BITS (OWNER_BITS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rsp          (rsp),
        .units_in_use (units_in_use),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

endmodule
